### design/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg: shared types for the positional list
// codes, state encoding and the command/status groups between controller
// and datapath
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int unsigned ACT_W = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STS_W = 2;
  localparam int unsigned CNT_W = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [STS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // what the latched word turns out to do
  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_INS,
    OP_DEL
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;    // capture input word
    logic init;    // set up shift pointer
    logic rd_pos;  // read entry at position
    logic shift;   // move one entry
    logic put;     // write new value
    logic finish;  // update count, load result register
  } cmd_t;

  typedef struct packed {
    op_e  kind;
    logic need_shift;
    logic last;
    logic out_free;
  } sts_t;

endpackage

### design/plid_if.sv
// ----------------------------------------------------------------------------
// plid_in_if / plid_out_if: valid/ready channels of the positional list
// one interface per direction, source and sink modports
// ----------------------------------------------------------------------------
interface plid_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  position;
  logic signed [31:0] value;

  modport source (output valid, output action, output position, output value,
                  input ready);
  modport sink   (input valid, input action, input position, input value,
                  output ready);
endinterface

interface plid_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_value;
  logic [1:0]  status;
  logic [6:0]  entry_count;

  modport source (output valid, output read_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input read_value, input status,
                  input entry_count, output ready);
endinterface

### design/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with insert, delete and read
// controller plus datapath around one cell memory of DEPTH entries
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to DEPTH signed 32-bit entries in a
// single cell memory with one write and one registered read port. Each input
// word is an insert, delete or read at a zero-based position, and each gives
// exactly one result word with the read value (zero unless a good read), a
// status (done, list full, position out of range) and the entry count after
// the action. Errors leave the list untouched; an insert into an empty list
// ignores the position; action code 3 does nothing and reports done. One word
// is handled at a time. An insert or a delete also moves the tail of the list,
// k entries, where k is count - position for insert and count - position - 1
// for delete. The memory's single write port sets the pace: moving the tail
// moves one entry per cycle. A result may wait on the output register; the
// block holds in its last step until it is taken.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
  import plid_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  plid_in_if.sink    in_i,
  plid_out_if.source out_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, classify, move the tail, write, report
  plid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: word registers, count, cell memory and result register
  plid_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (in_i.action),
    .position_i    (in_i.position),
    .value_i       (in_i.value),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .read_value_o  (out_o.read_value),
    .status_o      (out_o.status),
    .entry_count_o (out_o.entry_count),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

### design/plid_ram.sv
// ----------------------------------------------------------------------------
// plid_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module plid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/plid_ctrl.sv
// ----------------------------------------------------------------------------
// plid_ctrl: sequencing for the positional list
// walks each word through decide, shift, write and result steps
// ----------------------------------------------------------------------------
module plid_ctrl
  import plid_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        case (sts_i.kind)
          OP_INS:  state_d = sts_i.need_shift ? S_SHIFT : S_PUT;
          OP_DEL:  state_d = sts_i.need_shift ? S_SHIFT : S_DONE;
          default: state_d = S_DONE;
        endcase
      end
      S_SHIFT: begin
        if (sts_i.last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = (sts_i.kind == OP_INS) ? S_PUT : S_DONE;
      end
      S_PUT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DECIDE: begin
        cmd_o.init   = 1'b1;
        cmd_o.rd_pos = (sts_i.kind == OP_READ);
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
      end
      S_DONE: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### design/plid_dp.sv
// ----------------------------------------------------------------------------
// plid_dp: datapath of the positional list
// word registers, count, shift pointer, cell memory and result register
// ----------------------------------------------------------------------------
module plid_dp
  import plid_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ACT_W-1:0]        action_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [STS_W-1:0]        status_o,
  output logic [CNT_W-1:0]        entry_count_o,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > POS_W + 1) ? LW : POS_W + 1;

  logic [ACT_W-1:0] act_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [LW-1:0]    len_q, len_d;
  logic [AW-1:0]    src_q, src_d;
  logic [AW-1:0]    waddr_q, waddr_d;
  logic             pend_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_rd_q;
  logic [STS_W-1:0] out_st_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic [CW-1:0]    pos_c, len_c;
  logic [AW-1:0]    pos_a, top_a;
  op_e              kind;
  status_e          st;
  logic             need_shift;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  assign pos_c = CW'(pos_q);
  assign len_c = CW'(len_q);
  assign pos_a = AW'(pos_q);
  assign top_a = AW'(len_q - LW'(1));

  // classify the latched word against the current count
  always_comb begin
    kind       = OP_NONE;
    st         = ST_DONE;
    need_shift = 1'b0;
    case (act_q)
      ACT_INSERT: begin
        if (len_q == LW'(DEPTH)) begin
          st = ST_FULL;
        end else if (len_q == '0) begin
          kind = OP_INS;
        end else if (pos_c > len_c) begin
          st = ST_RANGE;
        end else begin
          kind       = OP_INS;
          need_shift = (pos_c < len_c);
        end
      end
      ACT_DELETE: begin
        if (pos_c >= len_c) begin
          st = ST_RANGE;
        end else begin
          kind       = OP_DEL;
          need_shift = ((pos_c + CW'(1)) < len_c);
        end
      end
      ACT_READ: begin
        if (pos_c >= len_c) begin
          st = ST_RANGE;
        end else begin
          kind = OP_READ;
        end
      end
      default: begin
        kind = OP_NONE;
      end
    endcase
  end

  assign sts_o.kind       = kind;
  assign sts_o.need_shift = need_shift;
  assign sts_o.last       = (kind == OP_INS) ? (src_q == pos_a) : (src_q == top_a);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // shift pointer: insert walks down from the top, delete walks up
  always_comb begin
    src_d   = src_q;
    waddr_d = waddr_q;
    if (cmd_i.init) begin
      src_d = (kind == OP_INS) ? top_a : pos_a + AW'(1);
    end else if (cmd_i.shift) begin
      if (kind == OP_INS) begin
        src_d   = src_q - AW'(1);
        waddr_d = src_q + AW'(1);
      end else begin
        src_d   = src_q + AW'(1);
        waddr_d = src_q - AW'(1);
      end
    end
  end

  always_comb begin
    case (kind)
      OP_INS:  len_d = len_q + LW'(1);
      OP_DEL:  len_d = len_q - LW'(1);
      default: len_d = len_q;
    endcase
  end

  // memory ports: pending move has the write port, then the new value
  assign ram_re    = cmd_i.rd_pos || cmd_i.shift;
  assign ram_raddr = cmd_i.rd_pos ? pos_a : src_q;
  assign ram_we    = pend_q || cmd_i.put;
  assign ram_waddr = pend_q ? waddr_q : ((len_q == '0) ? '0 : pos_a);
  assign ram_wdata = pend_q ? ram_rdata : val_q;

  plid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.shift;
      if (cmd_i.finish) begin
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    src_q   <= src_d;
    waddr_q <= waddr_d;
    if (cmd_i.finish) begin
      out_rd_q  <= (kind == OP_READ) ? ram_rdata : '0;
      out_st_q  <= st;
      out_cnt_q <= CNT_W'(len_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_rd_q;
  assign status_o      = out_st_q;
  assign entry_count_o = out_cnt_q;

endmodule

### tb/sv/tb_positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// tb_positional_list_insert_delete: self-checking bench for the positional list
// drives insert, delete, read and no-op words through the valid/ready input,
// keeps a shadow copy of the list to predict each result word, and compares
// every result field by field under random idling and a long output stall
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete;
  import plid_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned IDLE_PCT    = 32;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned STALL_LEN   = 300;

  // action code 3 has no name in the package: the block treats it as a no-op
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // one result word as the block should give it
  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    status_e                 status;
    logic [CNT_W-1:0]        entry_count;
  } list_result_t;

  logic clk;
  logic rst_n;

  plid_in_if  in_ch ();
  plid_out_if out_ch ();

  positional_list_insert_delete #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // shadow copy of the list, updated at each accepted input word
  logic signed [VAL_W-1:0] shadow_cells [DEPTH];
  int unsigned             shadow_len = 0;

  // predicted result words, oldest first
  list_result_t pending_results [$];

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned word_cnt     = 0;

  // what the run reached
  int unsigned n_ins   = 0;
  int unsigned n_del   = 0;
  int unsigned n_read  = 0;
  int unsigned n_noop  = 0;
  int unsigned n_full  = 0;
  int unsigned n_range = 0;
  int unsigned peak_len = 0;

  // knobs shared by the test tasks and the two channel processes
  bit          no_idle       = 1'b0;
  int unsigned stall_request = 0;

  // --------------------------------------------------------------------------
  // clock and run-length guard
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d words sent, %0d results outstanding",
                 cycle_cnt, word_cnt, pending_results.size());
        $display("tb_positional_list_insert_delete NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // list predictor: applies one action to the shadow list, returns the result
  // --------------------------------------------------------------------------
  function automatic list_result_t apply_action(input logic [ACT_W-1:0] act,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [VAL_W-1:0] val);
    list_result_t res;
    res.read_value = '0;
    res.status     = ST_DONE;
    case (act)
      ACT_INSERT: begin
        // full check wins over the position check
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else if (shadow_len == 0) begin
          // empty list: position does not matter, value lands at entry 0
          shadow_cells[0] = val;
          shadow_len      = 1;
        end else if (pos > shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          // position equal to the count appends
          for (int i = shadow_len; i > pos; i--)
            shadow_cells[POS_W'(i)] = shadow_cells[POS_W'(i-1)];
          shadow_cells[pos] = val;
          shadow_len++;
        end
        if (res.status == ST_DONE) n_ins++;
      end
      ACT_DELETE: begin
        if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < shadow_len; i++)
            shadow_cells[POS_W'(i)] = shadow_cells[POS_W'(i+1)];
          shadow_len--;
          n_del++;
        end
      end
      ACT_READ: begin
        if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = shadow_cells[pos];
          n_read++;
        end
      end
      default: n_noop++;
    endcase
    if (res.status == ST_FULL)  n_full++;
    if (res.status == ST_RANGE) n_range++;
    if (shadow_len > peak_len)  peak_len = shadow_len;
    res.entry_count = CNT_W'(shadow_len);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // input side: offers one word, waits for the handshake, records the prediction
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    // random gap before the word; valid stays high when there is none
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.position <= pos;
    in_ch.value    <= val;
    @(posedge clk);
    // ready is sampled as it was just before this edge
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(apply_action(act, pos, val));
    word_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // output side: random ready, long hold-off on request, checks each result
  // --------------------------------------------------------------------------
  task automatic report_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN) $display("cycle %0d: %s", cycle_cnt, msg);
  endtask

  initial begin
    int unsigned  hold_left;
    list_result_t want;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        result_cnt++;
        if (pending_results.size() == 0) begin
          report_error($sformatf("result word with nothing expected: value %0d status %0d count %0d",
                                 out_ch.read_value, out_ch.status, out_ch.entry_count));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.read_value !== want.read_value || out_ch.status !== want.status ||
              out_ch.entry_count !== want.entry_count)
            report_error($sformatf({"result %0d: expected value %0d status %0d count %0d,",
                                    " got value %0d status %0d count %0d"},
                                   result_cnt, want.read_value, want.status, want.entry_count,
                                   out_ch.read_value, out_ch.status, out_ch.entry_count));
        end
      end
      // a stall request from a test task is taken over and counted down here
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // mostly a legal index for the action, biased to both ends, sometimes anything
  function automatic logic [POS_W-1:0] pick_index(input bit for_insert);
    int unsigned top;
    if ($urandom_range(19) == 0 || (!for_insert && shadow_len == 0))
      return POS_W'($urandom_range(DEPTH - 1));
    top = for_insert ? shadow_len : shadow_len - 1;
    if (top > DEPTH - 1) top = DEPTH - 1;
    case ($urandom_range(7))
      0:       return '0;
      1:       return POS_W'(top);
      default: return POS_W'($urandom_range(top));
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // edges of every field and each special case on a short list
  task automatic test_directed();
    send_word(ACT_READ,   6'd0,  '0);            // read on empty list
    send_word(ACT_DELETE, 6'd0,  '0);            // delete on empty list
    send_word(ACT_NOP,    6'd63, '1);            // unused code on empty list
    send_word(ACT_INSERT, 6'd63, VAL_MAX);       // empty list ignores position
    send_word(ACT_INSERT, 6'd0,  VAL_MIN);       // insert at the front
    send_word(ACT_INSERT, 6'd2,  '1);            // position equal to count appends
    send_word(ACT_INSERT, 6'd63, '0);            // position above count
    send_word(ACT_INSERT, 6'd1,  32'sh5a5a_5a5a); // insert in the middle
    for (int i = 0; i < 5; i++) send_word(ACT_READ, POS_W'(i), '1); // last one past end
    send_word(ACT_DELETE, 6'd4,  '0);            // delete at count
    send_word(ACT_DELETE, 6'd3,  '0);            // delete the last entry
    send_word(ACT_DELETE, 6'd0,  '0);            // delete the first entry
    send_word(ACT_READ,   6'd0,  '0);
    send_word(ACT_READ,   6'd1,  '0);
    send_word(ACT_NOP,    6'd0,  VAL_MIN);       // unused code on a live list
    send_word(ACT_DELETE, 6'd1,  '0);
    send_word(ACT_DELETE, 6'd0,  '0);            // back to empty
    send_word(ACT_INSERT, 6'd0,  32'sd1);
    send_word(ACT_DELETE, 6'd0,  '0);
  endtask

  // grow to full with random positions, poke the full list, then empty it
  task automatic test_fill_and_drain();
    while (shadow_len < DEPTH) send_word(ACT_INSERT, pick_index(1'b1), pick_value());
    send_word(ACT_INSERT, 6'd63, pick_value());  // full list, legal position
    send_word(ACT_INSERT, 6'd0,  pick_value());  // full list, front
    send_word(ACT_READ,   6'd63, '0);            // highest index while full
    send_word(ACT_READ,   6'd0,  '0);
    send_word(ACT_DELETE, 6'd63, '0);            // last entry of a full list
    send_word(ACT_INSERT, 6'd63, pick_value());  // append back up to full
    while (shadow_len > 0) begin
      if ($urandom_range(3) == 0) send_word(ACT_READ, pick_index(1'b0), '0);
      send_word(ACT_DELETE, pick_index(1'b0), '0);
    end
  endtask

  // mostly legal actions that wander between empty and full, some noise
  task automatic test_random_mix(input int unsigned n_words);
    bit               growing;
    int unsigned      r;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    growing = 1'b1;
    repeat (n_words) begin
      if (shadow_len >= DEPTH)              growing = 1'b0;
      else if (shadow_len == 0)             growing = 1'b1;
      else if ($urandom_range(49) == 0)     growing = !growing;
      r = $urandom_range(99);
      if (r < 6) begin
        // noise: any code at any position
        act = ACT_W'($urandom_range(3));
        pos = POS_W'($urandom_range(DEPTH - 1));
      end else if (r < 26) begin
        act = ACT_READ;
        pos = pick_index(1'b0);
      end else if (r < (growing ? 76 : 41)) begin
        act = ACT_INSERT;
        pos = pick_index(1'b1);
      end else begin
        act = ACT_DELETE;
        pos = pick_index(1'b0);
      end
      send_word(act, pos, pick_value());
    end
  endtask

  // no idling on either side for a while
  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_mix(150);
    no_idle = 1'b0;
  endtask

  // receiver holds off long enough that the block stops taking input
  task automatic test_output_stall();
    stall_request = STALL_LEN;
    test_random_mix(20);
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n <= 1'b0;
    for (int i = 0; i < DEPTH; i++) shadow_cells[POS_W'(i)] = '0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_INSERT;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_back_to_back();
    test_output_stall();
    test_random_mix(1200);
    in_ch.valid <= 1'b0;

    // let the last results come out, then a few spare cycles
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d words: %0d inserts, %0d deletes, %0d reads done, %0d no-ops",
             word_cnt, n_ins, n_del, n_read, n_noop);
    $display("%0d full rejects, %0d position rejects, longest list %0d, %0d results checked",
             n_full, n_range, peak_len, result_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_positional_list_insert_delete OK");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("tb_positional_list_insert_delete NOT OK");
    end
    $finish;
  end

endmodule
